/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AST_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define AST_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/tokwf_pkg.sv */
`timescale 1ns / 1ps

package tokwf_pkg;

  localparam int LEN_W = 7;

  localparam logic [1:0] CLS_ALPHA    = 2'd0;
  localparam logic [1:0] CLS_PRINT    = 2'd1;
  localparam logic [1:0] CLS_NONSPACE = 2'd2;

  localparam logic [LEN_W-1:0] MAX_KEEP_RESET = 7'd59;

  typedef enum logic [2:0] {
    REG_START_CLASS,
    REG_CONTINUE_CLASS,
    REG_KEEP_CASE,
    REG_MAX_KEEP_LENGTH,
    REG_STRIP_TRAILING,
    REG_DROP_NON_ALPHA,
    REG_DIGIT_LIMIT
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]       start_class;
    logic [1:0]       continue_class;
    logic             keep_case;
    logic [LEN_W-1:0] max_keep_length;
    logic             strip_trailing;
    logic             drop_non_alpha;
    logic [LEN_W-1:0] digit_limit;
  } cfg_t;

  // One classified byte: close the open word, open a new one, or append.
  typedef struct packed {
    logic       do_close;
    logic       do_open;
    logic       do_append;
    logic [7:0] ch;
  } cmd_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic in_class(input logic [1:0] cls, input logic [7:0] b);
    logic r;
    case (cls)
      CLS_ALPHA:    r = is_alpha(b);
      CLS_PRINT:    r = b >= 8'h21 && b <= 8'h7E;
      CLS_NONSPACE: r = !(b == 8'h20 || (b >= 8'h09 && b <= 8'h0D));
      default:      r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] b, input logic keep_case);
    logic [7:0] r;
    r = b;
    if (!keep_case && b >= 8'h41 && b <= 8'h5A) r = b + 8'h20;
    return r;
  endfunction

endpackage

/* src/tokwf_ifs.sv */
`timescale 1ns / 1ps

interface tokwf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface tokwf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_char;
  logic [6:0] token_length;
  logic       last_char;
  logic       overflow;

  modport source (output valid, output token_char, output token_length,
                  output last_char, output overflow, input ready);
  modport sink (input valid, input token_char, input token_length,
                input last_char, input overflow, output ready);
endinterface

/* src/tokwf_front.sv */
`timescale 1ns / 1ps

module tokwf_front (
  input  logic             clk,
  input  logic             rst_n,
  tokwf_in_if.sink         in_tok,
  input  tokwf_pkg::cfg_t  cfg,
  output logic             q_push,
  output tokwf_pkg::cmd_t  q_cmd,
  input  logic             q_ready
);

  logic inside_r, inside_nxt;
  logic acc, cont, start;
  tokwf_pkg::cmd_t cmd;

  assign in_tok.ready = q_ready;
  assign acc = in_tok.valid && q_ready;
  assign cont = tokwf_pkg::in_class(cfg.continue_class, in_tok.in_byte);
  assign start = tokwf_pkg::in_class(cfg.start_class, in_tok.in_byte);

  always_comb begin
    cmd = '0;
    cmd.ch = tokwf_pkg::fold(in_tok.in_byte, cfg.keep_case);
    inside_nxt = inside_r;
    if (in_tok.in_byte == 8'h00) begin
      cmd.do_close = inside_r;
      inside_nxt = 1'b0;
    end else if (inside_r && cont) begin
      cmd.do_append = 1'b1;
    end else begin
      // the terminating byte may itself open the next word
      cmd.do_close = inside_r;
      cmd.do_open = start;
      inside_nxt = start;
    end
  end

  assign q_cmd = cmd;
  assign q_push = in_tok.valid && (cmd.do_close || cmd.do_open || cmd.do_append);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
    end else if (acc) begin
      inside_r <= inside_nxt;
    end
  end

endmodule

/* src/tokwf_queue.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tokwf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tokwf_pkg::cmd_t push_cmd,
  output logic            ready,
  input  logic            pop,
  output logic            head_valid,
  output tokwf_pkg::cmd_t head
);

  tokwf_pkg::cmd_t ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign ready = cnt_r != 2'd2;
  assign head_valid = cnt_r != 2'd0;
  assign head = ent_r[rp_r];
  assign do_push = push && ready;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  `AST_IMPL(q_pop_has_entry, clk, rst_n, pop, head_valid)

endmodule

/* src/tokwf_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tokwf_back #(
  parameter int MAX_WORD = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tokwf_pkg::cfg_t cfg,
  input  logic            head_valid,
  input  tokwf_pkg::cmd_t head,
  output logic            pop,
  tokwf_out_if.source     out_tok
);

  localparam int AW = $clog2(MAX_WORD);
  localparam int CW = $clog2(MAX_WORD + 1);
  localparam int LW = tokwf_pkg::LEN_W;

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  state_t state_r, state_nxt;

  // word statistics, kept up to date as bytes arrive
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] slen_r, slen_nxt;       // length up to the last letter
  logic          na_any_r, na_any_nxt;
  logic          na_strip_r, na_strip_nxt;
  logic [CW-1:0] dig_r, dig_nxt;
  logic [CW-1:0] dig_strip_r, dig_strip_nxt;

  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] len_r, len_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_char_r, out_char_nxt;
  logic [LW-1:0] out_len_r, out_len_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic [7:0]    mem [MAX_WORD];
  logic [7:0]    mem_q;
  logic          we;
  logic [AW-1:0] wr_addr;

  logic          slot_free, keep, last;
  logic [CW-1:0] klen, kdig;
  logic          kna, clear, room;
  logic [CW-1:0] b_cnt, b_dig;
  logic          b_na_any;

  assign slot_free = !out_valid_r || out_tok.ready;
  assign klen = cfg.strip_trailing ? slen_r : cnt_r;
  assign kdig = cfg.strip_trailing ? dig_strip_r : dig_r;
  assign kna  = cfg.strip_trailing ? na_strip_r : na_any_r;
  assign keep = !ovf_r
             && (cfg.max_keep_length == '0 || LW'(cnt_r) <= cfg.max_keep_length)
             && (!cfg.strip_trailing || slen_r != '0)
             && (!cfg.drop_non_alpha || !kna)
             && (cfg.digit_limit == '0 || LW'(kdig) <= cfg.digit_limit)
             && klen >= CW'(2);
  assign last = idx_r == len_r - CW'(1);

  // sequencing: emit kept words and overflow tokens, retire each command
  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    len_nxt = len_r;
    pop = 1'b0;
    out_valid_nxt = out_valid_r && !out_tok.ready;
    out_char_nxt = out_char_r;
    out_len_nxt = out_len_r;
    out_last_nxt = out_last_r;
    out_ovf_nxt = out_ovf_r;
    unique case (state_r)
      ST_IDLE: begin
        if (head_valid) begin
          if (head.do_close && ovf_r) begin
            if (slot_free) begin
              out_valid_nxt = 1'b1;
              out_char_nxt = 8'h00;
              out_len_nxt = '0;
              out_last_nxt = 1'b1;
              out_ovf_nxt = 1'b1;
              pop = 1'b1;
            end
          end else if (head.do_close && keep) begin
            state_nxt = ST_EMIT;
            idx_nxt = '0;
            len_nxt = klen;
          end else begin
            pop = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt = mem_q;
          out_len_nxt = LW'(len_r);
          out_last_nxt = last;
          out_ovf_nxt = 1'b0;
          idx_nxt = idx_r + CW'(1);
          if (last) begin
            pop = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // apply the retired command to the word state
  always_comb begin
    clear = head.do_close || head.do_open;
    room = cnt_r < CW'(MAX_WORD);
    b_cnt = clear ? '0 : cnt_r;
    b_dig = clear ? '0 : dig_r;
    b_na_any = clear ? 1'b0 : na_any_r;
    we = pop && (head.do_open || (head.do_append && room));
    wr_addr = head.do_open ? '0 : cnt_r[AW-1:0];
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    slen_nxt = slen_r;
    na_any_nxt = na_any_r;
    na_strip_nxt = na_strip_r;
    dig_nxt = dig_r;
    dig_strip_nxt = dig_strip_r;
    if (pop) begin
      if (clear) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
        slen_nxt = '0;
        na_any_nxt = 1'b0;
        na_strip_nxt = 1'b0;
        dig_nxt = '0;
        dig_strip_nxt = '0;
      end
      if (head.do_append && !room) ovf_nxt = 1'b1;
      if (we) begin
        cnt_nxt = b_cnt + CW'(1);
        if (tokwf_pkg::is_alpha(head.ch)) begin
          slen_nxt = b_cnt + CW'(1);
          na_strip_nxt = b_na_any;
          dig_strip_nxt = b_dig;
        end else begin
          na_any_nxt = 1'b1;
        end
        if (tokwf_pkg::is_digit(head.ch)) dig_nxt = b_dig + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= head.ch;
    mem_q <= mem[idx_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      slen_r      <= '0;
      na_any_r    <= 1'b0;
      na_strip_r  <= 1'b0;
      dig_r       <= '0;
      dig_strip_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      slen_r      <= slen_nxt;
      na_any_r    <= na_any_nxt;
      na_strip_r  <= na_strip_nxt;
      dig_r       <= dig_nxt;
      dig_strip_r <= dig_strip_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    len_r      <= len_nxt;
    out_char_r <= out_char_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tok.valid = out_valid_r;
  assign out_tok.token_char = out_char_r;
  assign out_tok.token_length = out_len_r;
  assign out_tok.last_char = out_last_r;
  assign out_tok.overflow = out_ovf_r;

  `AST_IMPL(bk_cnt_range, clk, rst_n, 1'b1, cnt_r <= CW'(MAX_WORD))
  `AST_IMPL(bk_ovf_full, clk, rst_n, ovf_r, cnt_r == CW'(MAX_WORD))
  `AST_IMPL(bk_emit_idx, clk, rst_n, state_r == ST_EMIT, idx_r < len_r)
  `AST_IMPL(bk_ovf_shape, clk, rst_n, out_valid_r && out_ovf_r,
            out_last_r && out_char_r == 8'h00)

endmodule

/* src/text_tokenizer_word_filter.sv */
`timescale 1ns / 1ps
// Word tokenizer with filtering.
// in_tok carries one byte per transaction; byte 0 ends the document and
// closes any open word. out_tok carries one transaction per byte of a kept
// word (last_char on the final byte), or a single overflow transaction for
// a word longer than MAX_WORD bytes. The cfg_ port writes the registers
// (start/continue class, case, length, strip, non-alpha, digit limits) at
// any edge with cfg_we high; write only while the block is idle.
// A front classifier takes one byte per cycle, while the queue has room,
// into a two-entry command queue; the back end stores bytes into a word
// buffer at one per cycle while it is not emitting a word. When a kept
// word closes, the back end reads the buffer one byte per cycle while
// out_tok accepts; each byte passes the buffer read register and then
// the output register.
// A stalled out_tok holds its output register; the queue then fills and
// in_tok.ready drops. Reset clears the word state and loads register
// defaults (max_keep_length 59, all others 0); no clearing pass is needed.
module text_tokenizer_word_filter #(
  parameter int MAX_WORD = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  tokwf_in_if.sink    in_tok,
  tokwf_out_if.source out_tok,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_wdata
);

  tokwf_pkg::cfg_t cfg_r;
  tokwf_pkg::cmd_t q_cmd, head;
  logic q_push, q_ready, pop, head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{start_class: 2'd0, continue_class: 2'd0, keep_case: 1'b0,
                 max_keep_length: tokwf_pkg::MAX_KEEP_RESET, strip_trailing: 1'b0,
                 drop_non_alpha: 1'b0, digit_limit: 7'd0};
    end else if (cfg_we) begin
      unique case (tokwf_pkg::reg_idx_t'(cfg_index))
        tokwf_pkg::REG_START_CLASS:     cfg_r.start_class <= cfg_wdata[1:0];
        tokwf_pkg::REG_CONTINUE_CLASS:  cfg_r.continue_class <= cfg_wdata[1:0];
        tokwf_pkg::REG_KEEP_CASE:       cfg_r.keep_case <= cfg_wdata[0];
        tokwf_pkg::REG_MAX_KEEP_LENGTH: cfg_r.max_keep_length <= cfg_wdata;
        tokwf_pkg::REG_STRIP_TRAILING:  cfg_r.strip_trailing <= cfg_wdata[0];
        tokwf_pkg::REG_DROP_NON_ALPHA:  cfg_r.drop_non_alpha <= cfg_wdata[0];
        tokwf_pkg::REG_DIGIT_LIMIT:     cfg_r.digit_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tokwf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tok  (in_tok),
    .cfg     (cfg_r),
    .q_push  (q_push),
    .q_cmd   (q_cmd),
    .q_ready (q_ready)
  );

  tokwf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .ready      (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tokwf_back #(
    .MAX_WORD (MAX_WORD)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tok    (out_tok)
  );

endmodule
